@@ rtl/meb_pkg.sv @@
// shared types, constants and the palette for the escape-time pixel block
// no dependencies
package meb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int P_W       = 2 * Q_W;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int IT_W      = 16;
    localparam int NUM_W     = 15;
    localparam int DIV_W     = NUM_W + FRAC_BITS;
    localparam int CNT_W     = 6;
    localparam int IDX_NUM_W = 21;

    localparam logic [Q_W-1:0] ONE_Q  = Q_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0] OFF_RE = Q_W'(((64'd21 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [P_W-1:0] ESC_THR = P_W'(64'd1 << (2 * FRAC_BITS + 2));
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [IT_W-1:0]  limit;
    } cfg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
    } point_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_IDX,
        B_OUT
    } back_state_t;

    function automatic logic [6:0] palette(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0:    c = 7'd40;
            4'd1:    c = 7'd104;
            4'd2:    c = 7'd44;
            4'd3:    c = 7'd46;
            4'd4:    c = 7'd106;
            4'd5:    c = 7'd45;
            4'd6:    c = 7'd105;
            4'd7:    c = 7'd42;
            4'd8:    c = 7'd102;
            4'd9:    c = 7'd41;
            4'd10:   c = 7'd43;
            4'd11:   c = 7'd103;
            4'd12:   c = 7'd100;
            4'd13:   c = 7'd107;
            4'd14:   c = 7'd47;
            default: c = 7'd40;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/meb_front.sv @@
// front end: takes a pixel word, clamps it and maps it to the point c
// by two bit-serial divisions; depends on meb_pkg
module meb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  meb_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [11:0]     in_x,
    input  logic [11:0]     in_y,
    output logic            push,
    input  logic            full,
    output meb_pkg::point_t push_data
);
    import meb_pkg::*;

    front_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;

    logic [DIV_W-1:0]   nr_reg, ni_reg;
    logic [DIM_W:0]     dr_reg;
    logic [DIM_W-1:0]   di_reg;
    logic [DIM_W:0]     rr_reg;
    logic [DIM_W-1:0]   ri_reg;
    logic [Q_W-1:0]     qr_reg, qi_reg;

    logic [COORD_W-1:0] pxc, pyc;
    logic [DIM_W+1:0]   tr;
    logic [DIM_W:0]     ti;
    logic               br, bi;

    always_comb
    begin
        pxc = in_x;
        pyc = in_y;
        if ({1'b0, in_x} >= cfg.width)
            pxc = COORD_W'(cfg.width - 1'b1);
        if ({1'b0, in_y} >= cfg.height)
            pyc = COORD_W'(cfg.height - 1'b1);
    end

    always_comb
    begin
        tr = {rr_reg, nr_reg[DIV_W-1]};
        ti = {ri_reg, ni_reg[DIV_W-1]};
        br = tr >= {1'b0, dr_reg};
        bi = ti >= {1'b0, di_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_DIV;
            F_DIV:   if (cnt_reg == LAST_STEP) state_next = F_PUSH;
            F_PUSH:  if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = state_reg == F_IDLE;
        push         = (state_reg == F_PUSH) && !full;
        push_data.cr = $signed(qr_reg - OFF_RE);
        push_data.ci = $signed(qi_reg - ONE_Q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_DIV)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE)
        begin
            nr_reg <= {NUM_W'({3'b0, pxc} * 15'd7), FRAC_BITS'(0)};
            ni_reg <= {NUM_W'({pyc, 1'b0}), FRAC_BITS'(0)};
            dr_reg <= {cfg.width, 1'b0};
            di_reg <= cfg.height;
            rr_reg <= '0;
            ri_reg <= '0;
            qr_reg <= '0;
            qi_reg <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            nr_reg <= {nr_reg[DIV_W-2:0], 1'b0};
            ni_reg <= {ni_reg[DIV_W-2:0], 1'b0};
            rr_reg <= br ? (DIM_W+1)'(tr - {1'b0, dr_reg}) : (DIM_W+1)'(tr);
            ri_reg <= bi ? DIM_W'(ti - {1'b0, di_reg}) : DIM_W'(ti);
            qr_reg <= {qr_reg[Q_W-2:0], br};
            qi_reg <= {qi_reg[Q_W-2:0], bi};
        end
    end

endmodule

@@ rtl/meb_queue.sv @@
// two-entry queue of mapped points between front and back
// depends on meb_pkg
module meb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  meb_pkg::point_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output meb_pkg::point_t pop_data
);
    import meb_pkg::*;

    point_t     mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

@@ rtl/meb_back.sv @@
// back end: runs z = z*z + c, then the palette index by a four-step divide
// and holds the result word; depends on meb_pkg
module meb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  meb_pkg::cfg_t   cfg,
    input  logic            empty,
    output logic            pop,
    input  meb_pkg::point_t pop_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     out_iter,
    output logic [3:0]      out_idx,
    output logic [6:0]      out_color
);
    import meb_pkg::*;

    back_state_t state_reg, state_next;
    logic [1:0]  step_reg;
    logic        valid_reg;

    logic signed [Q_W-1:0] cr_reg, ci_reg, x_reg, y_reg;
    logic signed [P_W-1:0] xx_reg, yy_reg, xy_reg;
    logic [IT_W-1:0]       it_reg, lim_reg;
    logic [IDX_NUM_W-1:0]  num_reg;
    logic [3:0]            q_reg;
    logic [IT_W-1:0]       it_o_reg;
    logic [3:0]            idx_o_reg;

    logic [P_W-1:0]        sum;
    logic signed [P_W-1:0] diff;
    logic                  esc, last_it, load;
    logic [IDX_NUM_W-1:0]  dsh;
    logic [IT_W-1:0]       it_inc;

    always_comb
    begin
        sum     = $unsigned(xx_reg) + $unsigned(yy_reg);
        diff    = xx_reg - yy_reg;
        esc     = sum > ESC_THR;
        it_inc  = it_reg + 1'b1;
        last_it = it_inc == lim_reg;
        dsh     = IDX_NUM_W'({lim_reg, 1'b0}) << step_reg;
        load    = (state_reg == B_OUT) && (!valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!empty) state_next = B_MUL;
            B_MUL:   state_next = B_UPD;
            B_UPD:   if (esc || last_it) state_next = B_IDX;
                     else state_next = B_MUL;
            B_IDX:   if (step_reg == 2'd0) state_next = B_OUT;
            B_OUT:   if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !empty;
        out_valid = valid_reg;
        out_iter  = it_o_reg;
        out_idx   = idx_o_reg;
        out_color = palette(idx_o_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDX)
                step_reg <= step_reg - 1'b1;
            else
                step_reg <= 2'd3;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                cr_reg  <= pop_data.cr;
                ci_reg  <= pop_data.ci;
                x_reg   <= '0;
                y_reg   <= '0;
                it_reg  <= '0;
                lim_reg <= cfg.limit;
            end
            B_MUL:
            begin
                xx_reg <= x_reg * x_reg;
                yy_reg <= y_reg * y_reg;
                xy_reg <= x_reg * y_reg;
            end
            B_UPD:
            begin
                if (!esc)
                begin
                    x_reg  <= diff[FRAC_BITS +: Q_W] + cr_reg;
                    y_reg  <= xy_reg[FRAC_BITS-1 +: Q_W] + ci_reg;
                    it_reg <= it_inc;
                end
                num_reg <= IDX_NUM_W'((esc ? it_reg : it_inc) * 21'd30)
                           + IDX_NUM_W'(lim_reg);
                q_reg   <= '0;
            end
            B_IDX:
            begin
                if (num_reg >= dsh)
                begin
                    num_reg        <= num_reg - dsh;
                    q_reg[step_reg] <= 1'b1;
                end
            end
            B_OUT:
            begin
                if (load)
                begin
                    it_o_reg  <= it_reg;
                    idx_o_reg <= q_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/mandelbrot_escape_time_pixel.sv @@
// top level of the escape-time pixel block: config registers, front, queue, back
// depends on meb_pkg, meb_front, meb_queue, meb_back
//
// channel   dir  signals                          contents
// s_*       in   s_tvalid s_tready s_tdata[23:0]   pixel word
// m_*       out  m_tvalid m_tready m_tdata[31:0]   result word
// cfg_*     in   cfg_we cfg_addr[1:0] cfg_wdata    register write
//
// front: the two serial divides run side by side, then a push into
// a two-entry queue; back: a pop, passes of the multiply loop (multiply,
// then update), the palette divide and a load of the output word,
// with passes = iterations + 1 on escape and passes = iterations at the limit.
// reset returns the registers to 80, 25 and 40. a stalled result word stops
// the back once its next word is ready; the front goes on until the queue is full.
module mandelbrot_escape_time_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_x, pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // iterations, palette_index, color_code, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import meb_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [IT_W-1:0]  limit_reg;
    cfg_t             cfg;

    logic   push, full, pop, empty;
    point_t push_data, pop_data;

    logic [15:0] iter;
    logic [3:0]  idx;
    logic [6:0]  color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(80);
            height_reg <= DIM_W'(25);
            limit_reg  <= IT_W'(40);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.width  = width_reg;
        cfg.height = height_reg;
        cfg.limit  = limit_reg;
        if (width_reg == '0)
            cfg.width = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_DIM))
            cfg.width = DIM_W'(MAX_DIM);
        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_DIM))
            cfg.height = DIM_W'(MAX_DIM);
        if (limit_reg == '0)
            cfg.limit = IT_W'(1);
    end

    meb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[11:0]),
        .in_y      (s_tdata[23:12]),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    meb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    meb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_iter  (iter),
        .out_idx   (idx),
        .out_color (color)
    );

    assign m_tdata = {5'b0, color, idx, iter};

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the escape-time pixel block
// depends on meb_pkg and mandelbrot_escape_time_pixel; expected words come from an
// in-bench escape-time predictor, drive on falling edges, sample on rising edges
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import meb_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0]  color_code;
        logic [3:0]  palette_index;
        logic [15:0] iterations;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] limit_reg;

    logic [23:0]   pixel_q[$];
    pixel_result_t result_q[$];
    logic          pixel_sent = 1'b0;
    logic          quiet = 1'b0;
    logic          hold_until_drained = 1'b0;
    int            error_count = 0;
    int            stuck_cycles = 0;

    logic [6:0] color_table[16] = '{7'd40, 7'd104, 7'd44, 7'd46, 7'd106, 7'd45, 7'd105,
        7'd42, 7'd102, 7'd41, 7'd43, 7'd103, 7'd100, 7'd107, 7'd47, 7'd40};

    mandelbrot_escape_time_pixel dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic pixel_result_t escape_time(input logic [11:0] px_in,
                                                  input logic [11:0] py_in);
        longint unsigned w, h, lim, px, py, it, idx;
        longint cr, ci, x, y, off_re;
        logic signed [127:0] xw, yw, xx, yy, xy, esc;
        pixel_result_t r;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        px = (px_in >= w) ? w - 1 : px_in;
        py = (py_in >= h) ? h - 1 : py_in;
        off_re = longint'(((64'd21 << FRAC_BITS) + 64'd5) / 64'd10);
        cr = longint'(((px * 7) << FRAC_BITS) / (2 * w)) - off_re;
        ci = longint'(((py * 2) << FRAC_BITS) / h) - (longint'(1) << FRAC_BITS);
        esc = 128'sd1 <<< (2 * FRAC_BITS + 2);
        x = 0;
        y = 0;
        it = 0;
        while (it < lim)
        begin
            xw = x;
            yw = y;
            xx = xw * xw;
            yy = yw * yw;
            if (xx + yy > esc)
                break;
            xy = xw * yw;
            x = longint'((xx - yy) >>> FRAC_BITS) + cr;
            y = longint'(xy >>> (FRAC_BITS - 1)) + ci;
            it++;
        end
        idx = (it * 30 + lim) / (2 * lim);
        if (idx > 15)
            idx = 15;
        r.iterations = it[15:0];
        r.palette_index = idx[3:0];
        r.color_code = color_table[idx[3:0]];
        return r;
    endfunction

    // pixel word and result ready driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || pixel_sent))
        begin
            if (pixel_q.size() != 0 && !(hold_until_drained && result_q.size() != 0)
                && (quiet || $urandom_range(99) >= 32))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
        if (rst_n)
            m_tready <= quiet || ($urandom_range(99) >= 32);
    end

    // monitor, predictor feed and watchdog
    always @(posedge clk)
    begin
        pixel_result_t want, got;
        pixel_sent <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            result_q.push_back(escape_time(s_tdata[11:0], s_tdata[23:12]));
        if (m_tvalid && m_tready)
        begin
            got = pixel_result_t'(m_tdata[26:0]);
            if (result_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (got.iterations !== want.iterations)
                begin
                    $error("iterations exp %0d got %0d", want.iterations, got.iterations);
                    error_count++;
                end
                if (got.palette_index !== want.palette_index)
                begin
                    $error("palette_index exp %0d got %0d", want.palette_index,
                           got.palette_index);
                    error_count++;
                end
                if (got.color_code !== want.color_code)
                begin
                    $error("color_code exp %0d got %0d", want.color_code, got.color_code);
                    error_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL mandelbrot_escape_time_pixel");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  width_reg = value[12:0];
            REG_HEIGHT: height_reg = value[12:0];
            REG_LIMIT:  limit_reg = value;
            default:    ;
        endcase
    endtask

    task automatic drain;
        wait (pixel_q.size() == 0 && !s_tvalid && result_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic send(input int px, input int py);
        pixel_q.push_back({12'(py), 12'(px)});
    endtask

    initial
    begin
        int w, h;
        width_reg = 13'd80;
        height_reg = 13'd25;
        limit_reg = 16'd40;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, out of image pixels, points in and near the set
        send(0, 0);
        send(79, 24);
        send(4095, 4095);
        send(100, 30);
        send(48, 12);
        send(40, 12);
        send(2730, 1365);
        send(1365, 2730);
        drain();

        // zero dimensions and zero limit clamp up
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_LIMIT, 16'd0);
        send(0, 0);
        send(4095, 4095);
        send(7, 3);
        drain();

        // oversized dimensions clamp down, limit one
        write_reg(REG_WIDTH, 16'hffff);
        write_reg(REG_HEIGHT, 16'd5000);
        write_reg(REG_LIMIT, 16'd1);
        send(4095, 4095);
        send(0, 0);
        send(2048, 2048);
        drain();

        // full iteration limit on a point inside the set and one outside, and a write to the unused register
        write_reg(REG_WIDTH, 16'd80);
        write_reg(REG_HEIGHT, 16'd25);
        write_reg(REG_LIMIT, 16'd65535);
        write_reg(REG_UNUSED, 16'd7);
        send(48, 12);
        send(0, 0);
        drain();

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin w = 80; h = 25; end
                1: begin w = 4096; h = 4096; end
                2: begin w = 1; h = 1; end
                default: begin w = $urandom_range(1, 600); h = $urandom_range(1, 300); end
            endcase
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            write_reg(REG_LIMIT, 16'(ph == 5 ? 255 : $urandom_range(1, 120)));
            quiet = (ph == 3);
            for (int i = 0; i < 300; i++)
            begin
                if (ph == 4 && i == 150)
                begin
                    wait (pixel_q.size() == 0 && !s_tvalid);
                    hold_until_drained = 1'b1;
                end
                if (ph == 4 && i == 160)
                begin
                    wait (result_q.size() == 0);
                    hold_until_drained = 1'b0;
                end
                if ($urandom_range(9) < 7)
                    send($urandom_range(w - 1), $urandom_range(h - 1));
                else
                    send($urandom_range(4095), $urandom_range(4095));
            end
            drain();
        end
        quiet = 1'b0;

        if (error_count == 0)
            $display("PASS mandelbrot_escape_time_pixel");
        else
            $display("FAIL mandelbrot_escape_time_pixel");
        $finish;
    end

endmodule
